[design/ppd_pkg.sv]
// Shared constants for the per-pixel delay slit-scan block.
package ppd_pkg;

    localparam int PIX_W     = 8;
    localparam int MASK_W    = 8;
    localparam int GAIN_W    = 8;
    localparam int DIM_W     = 9;
    localparam int PROD_W    = MASK_W + GAIN_W;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    // delay index = floor(mask * gain * FRAMES / DELAY_DIV)
    localparam int unsigned DELAY_DIV = 30000;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DELAY_GAIN   = 2'd2;

    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 9'd256;
    localparam logic [GAIN_W-1:0] RST_DELAY_GAIN   = 8'd0;

endpackage

[design/ppd_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module ppd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/ppd_delay.sv]
// Delay index from mask*gain and read slot selection in the frame ring.
module ppd_delay #(
    parameter int FRAMES = 16
) (
    input  logic [ppd_pkg::PROD_W-1:0]  i_prod,
    input  logic [$clog2(FRAMES)-1:0]   i_slot,
    output logic [$clog2(FRAMES)-1:0]   o_rslot
);
    import ppd_pkg::*;

    localparam int SW = $clog2(FRAMES);

    logic [FRAMES-1:1] hit;
    logic [SW-1:0]     dly;
    logic [SW:0]       sum;

    // floor(p*F/DIV) >= k  <=>  p >= ceil(k*DIV/F); hit is a thermometer
    for (genvar k = 1; k < FRAMES; k++) begin : g_thr
        localparam int unsigned THR = (k * DELAY_DIV + FRAMES - 1) / FRAMES;
        assign hit[k] = ({16'd0, i_prod} >= THR);
    end

    always_comb begin
        dly = '0;
        for (int k = 1; k < FRAMES; k++) begin
            if (hit[k]) begin
                dly = SW'(k);
            end
        end
    end

    // (slot + F - 1 - d) mod F, the sum stays below 2F
    always_comb begin
        sum = {1'b0, i_slot} + (SW+1)'(FRAMES - 1) - {1'b0, dly};
        if (sum >= (SW+1)'(FRAMES)) begin
            o_rslot = SW'(sum - (SW+1)'(FRAMES));
        end else begin
            o_rslot = sum[SW-1:0];
        end
    end

endmodule

[design/ppd_raster.sv]
// Raster position and write slot counters.
module ppd_raster #(
    parameter int FRAMES     = 16,
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic [ppd_pkg::DIM_W-1:0]   i_frame_width,
    input  logic [ppd_pkg::DIM_W-1:0]   i_frame_height,
    output logic [((MAX_WIDTH * MAX_HEIGHT > 1) ?
                   $clog2(MAX_WIDTH * MAX_HEIGHT) : 1)-1:0] o_pos,
    output logic [$clog2(FRAMES)-1:0]   o_slot,
    output logic                        o_last
);
    import ppd_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(FRAMES);
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XW    = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
    localparam int YW    = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [SW-1:0] r_slot, n_slot;
    logic [XW-1:0] col_lim, w_ext;
    logic [YW-1:0] row_lim, h_ext;
    logic          row_end;

    // zero acts as one, oversize saturates to the maximum
    always_comb begin
        w_ext = XW'(i_frame_width);
        h_ext = YW'(i_frame_height);
        if (w_ext == '0) begin
            col_lim = '0;
        end else if (w_ext > XW'(MAX_WIDTH)) begin
            col_lim = XW'(MAX_WIDTH - 1);
        end else begin
            col_lim = w_ext - XW'(1);
        end
        if (h_ext == '0) begin
            row_lim = '0;
        end else if (h_ext > YW'(MAX_HEIGHT)) begin
            row_lim = YW'(MAX_HEIGHT - 1);
        end else begin
            row_lim = h_ext - YW'(1);
        end
    end

    assign row_end = (XW'(r_col) >= col_lim);
    assign o_last  = row_end && (YW'(r_row) >= row_lim);
    assign o_slot  = r_slot;
    assign o_pos   = AW'(r_row * MAX_WIDTH + r_col);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_slot = r_slot;
        if (i_advance) begin
            if (row_end) begin
                n_col = '0;
                if (o_last) begin
                    n_row  = '0;
                    n_slot = (r_slot == SW'(FRAMES - 1)) ? '0 : r_slot + SW'(1);
                end else begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

endmodule

[design/per_pixel_delay_slit_scan.sv]
// Top level of the per-pixel delay slit-scan block.
//
// Pixels stream in raster order, one per clock when both sides keep up. Each
// beat is written into the current slot of a FRAMES-deep frame ring and the
// output pixel is the one at the same position in slot (slot-1-d) mod FRAMES,
// d = floor(mask*gain*FRAMES/30000) clamped to FRAMES-1. The ring holds one
// word per raster position with all FRAMES pixels of that position, so each
// beat costs one read and one write of the store; that single read/write pair
// sets the rate at one pixel per cycle. Each accepted beat is held in stage 1
// during its store read, then waits in a two-beat output queue. After reset a
// clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT store words (65536 by default);
// input ready stays low during it, configuration writes are taken as usual.
module per_pixel_delay_slit_scan #(
    parameter int FRAMES     = 16,
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // pixel input
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ppd_pkg::PIX_W-1:0]    i_pixel_in,
    input  logic [ppd_pkg::MASK_W-1:0]   i_delay_mask,
    // pixel output
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ppd_pkg::PIX_W-1:0]    o_pixel_out,
    output logic                         o_frame_last,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppd_pkg::APB_AW-1:0]   paddr,
    input  logic [ppd_pkg::APB_DW-1:0]   pwdata,
    output logic [ppd_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import ppd_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(FRAMES);
    localparam int WW    = FRAMES * PIX_W;

    // configuration registers
    logic [DIM_W-1:0]  r_frame_width;
    logic [DIM_W-1:0]  r_frame_height;
    logic [GAIN_W-1:0] r_delay_gain;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_delay_gain   <= RST_DELAY_GAIN;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[DIM_W-1:0];
                REG_DELAY_GAIN:   r_delay_gain   <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            REG_DELAY_GAIN:   prdata = APB_DW'(r_delay_gain);
            default:          prdata = '0;
        endcase
    end

    // clearing pass after reset
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // raster position and write slot
    logic          in_acc;
    logic [AW-1:0] rs_pos;
    logic [SW-1:0] rs_slot;
    logic          rs_last;

    assign in_acc = i_valid && o_ready;

    ppd_raster #(
        .FRAMES     (FRAMES),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_raster (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (in_acc),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_pos          (rs_pos),
        .o_slot         (rs_slot),
        .o_last         (rs_last)
    );

    // stage 1: store read in flight
    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [PROD_W-1:0] r_s1_prod;
    logic [SW-1:0]     r_s1_slot;
    logic [AW-1:0]     r_s1_pos;
    logic              r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix  <= i_pixel_in;
            r_s1_prod <= i_delay_mask * r_delay_gain;
            r_s1_slot <= rs_slot;
            r_s1_pos  <= rs_pos;
            r_s1_last <= rs_last;
        end
    end

    // frame store, one word of FRAMES pixels per position
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic [WW-1:0] ram_rdata;
    logic [WW-1:0] base_word;
    logic [WW-1:0] merged;

    assign ram_we    = r_clr_busy || r_s1_valid;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_pos;
    assign ram_wdata = r_clr_busy ? '0 : merged;

    ppd_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rs_pos),
        .o_rdata (ram_rdata)
    );

    // the word written at the edge this beat's read was sampled is not in the
    // read data yet; take it from here instead
    logic          r_fw_valid;
    logic [AW-1:0] r_fw_pos;
    logic [WW-1:0] r_fw_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_pos  <= r_s1_pos;
        r_fw_word <= merged;
    end

    assign base_word = (r_fw_valid && (r_fw_pos == r_s1_pos)) ? r_fw_word : ram_rdata;

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            merged[i*PIX_W +: PIX_W] = (r_s1_slot == SW'(i)) ? r_s1_pix
                                                            : base_word[i*PIX_W +: PIX_W];
        end
    end

    // read slot; when it equals the write slot the new pixel comes through
    logic [SW-1:0]    rslot;
    logic [PIX_W-1:0] s1_out;

    ppd_delay #(
        .FRAMES (FRAMES)
    ) u_delay (
        .i_prod  (r_s1_prod),
        .i_slot  (r_s1_slot),
        .o_rslot (rslot)
    );

    assign s1_out = merged[rslot*PIX_W +: PIX_W];

    // two-beat output queue
    logic [PIX_W-1:0] r_q_pix  [2];
    logic             r_q_last [2];
    logic             r_q_wp;
    logic             r_q_rp;
    logic [1:0]       r_q_count;
    logic             q_pop;
    logic [2:0]       occ;

    assign q_pop = o_valid && i_ready;
    assign occ   = {1'b0, r_q_count} + {2'b00, r_s1_valid};

    // queue plus the beat in flight must leave room for a new beat
    assign o_ready = !r_clr_busy && ((occ - {2'b00, q_pop}) <= 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp    <= 1'b0;
            r_q_rp    <= 1'b0;
            r_q_count <= '0;
        end else begin
            if (r_s1_valid) begin
                r_q_wp <= ~r_q_wp;
            end
            if (q_pop) begin
                r_q_rp <= ~r_q_rp;
            end
            r_q_count <= r_q_count + {1'b0, r_s1_valid} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_q_pix[r_q_wp]  <= s1_out;
            r_q_last[r_q_wp] <= r_s1_last;
        end
    end

    assign o_valid      = (r_q_count != 2'd0);
    assign o_pixel_out  = r_q_pix[r_q_rp];
    assign o_frame_last = r_q_last[r_q_rp];

`ifndef SYNTHESIS
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_q_count} + {2'b00, r_s1_valid}) <= 3'd2)
        else $error("output queue overrun");

    a_no_beat_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s1_valid)
        else $error("pixel beat while clearing the store");

    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && rs_last) |=> (rs_slot != $past(rs_slot)))
        else $error("write slot did not advance at end of frame");
`endif

endmodule

[tb/sv/tb_per_pixel_delay_slit_scan.sv]
// Testbench for the per-pixel delay slit-scan block: directed and random pixel streams checked against a frame-ring predictor.
module tb_per_pixel_delay_slit_scan;
    import ppd_pkg::*;

    localparam int FRAMES       = 16;
    localparam int MAX_W        = 256;
    localparam int MAX_H        = 256;
    localparam int SLOT_W       = $clog2(FRAMES);
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEM_TARGET  = 1950;
    localparam int CALM_TAIL    = 250;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_slit_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [PIX_W-1:0]    i_pixel_in = '0;
    logic [MASK_W-1:0]   i_delay_mask = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [PIX_W-1:0]    o_pixel_out;
    logic                o_frame_last;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    per_pixel_delay_slit_scan #(
        .FRAMES     (FRAMES),
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel_in   (i_pixel_in),
        .i_delay_mask (i_delay_mask),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // predictor state: frame ring, raster position, registers
    bit   [PIX_W-1:0]  ring_mem [0:FRAMES*MAX_W*MAX_H-1];
    logic [SLOT_W-1:0] m_slot = '0;
    logic [7:0]        m_col = '0;
    logic [7:0]        m_row = '0;
    logic [DIM_W-1:0]  m_width = RST_FRAME_WIDTH;
    logic [DIM_W-1:0]  m_height = RST_FRAME_HEIGHT;
    logic [GAIN_W-1:0] m_gain = RST_DELAY_GAIN;

    t_slit_result expected_pixels[$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  frames_seen = 0;
    int  pixels_sent = 0;
    int  settings_used = 0;
    int  cycle_count = 0;
    bit  tx_idle_en = 1'b0;
    bit  rx_idle_en = 1'b0;
    int  hold_req = 0;
    int  hold_left = 0;
    int  rx_gap_left = 0;
    t_slit_result got_res;
    t_slit_result want_res;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("per_pixel_delay_slit_scan test failed");
        $finish;
    end

    // output side: long hold-offs on request, else random stall bursts when enabled
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (rx_gap_left != 0) begin
            i_ready <= 1'b0;
            rx_gap_left--;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            i_ready <= 1'b0;
            rx_gap_left = $urandom_range(0, 6);
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("MISMATCH at result %0d: %s expected %0d got %0d",
                 results_seen, what, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got_res.pixel = o_pixel_out;
            got_res.last  = o_frame_last;
            if (expected_pixels.size() == 0) begin
                report_mismatch("beat with nothing pending, pixel", 0, 32'(got_res.pixel));
            end else begin
                want_res = expected_pixels.pop_front();
                if (got_res.pixel !== want_res.pixel)
                    report_mismatch("pixel_out", 32'(want_res.pixel), 32'(got_res.pixel));
                if (got_res.last !== want_res.last)
                    report_mismatch("frame_last", 32'(want_res.last), 32'(got_res.last));
            end
            if (got_res.last === 1'b1)
                frames_seen++;
            results_seen++;
        end
    end

    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    task automatic predict_slit_scan(input logic [PIX_W-1:0] pix, input logic [MASK_W-1:0] mask);
        int unsigned w;
        int unsigned h;
        int unsigned d;
        int unsigned pos;
        logic [SLOT_W-1:0] rslot;
        t_slit_result r;
        w = eff_dim(m_width, MAX_W);
        h = eff_dim(m_height, MAX_H);
        pos = int'(m_row) * MAX_W + int'(m_col);
        ring_mem[int'(m_slot) * MAX_W * MAX_H + pos] = pix;
        d = (32'(mask) * 32'(m_gain) * FRAMES) / DELAY_DIV;
        if (d > FRAMES - 1)
            d = FRAMES - 1;
        rslot = m_slot - d[SLOT_W-1:0] - 1'b1;
        r.pixel = ring_mem[int'(rslot) * MAX_W * MAX_H + pos];
        r.last = 1'b0;
        if (m_col >= w - 1) begin
            m_col = '0;
            if (m_row >= h - 1) begin
                m_row = '0;
                r.last = 1'b1;
                m_slot = m_slot + 1'b1;
            end else begin
                m_row = m_row + 1'b1;
            end
        end else begin
            m_col = m_col + 1'b1;
        end
        expected_pixels.push_back(r);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] unused_rd;
        apb_access(1'b1, idx, val, unused_rd);
        case (idx)
            REG_FRAME_WIDTH:  m_width  = val[DIM_W-1:0];
            REG_FRAME_HEIGHT: m_height = val[DIM_W-1:0];
            REG_DELAY_GAIN:   m_gain   = val[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_registers();
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, REG_FRAME_WIDTH, '0, rd);
        if (rd !== APB_DW'(m_width))
            report_mismatch("frame_width readback", 32'(m_width), rd);
        apb_access(1'b0, REG_FRAME_HEIGHT, '0, rd);
        if (rd !== APB_DW'(m_height))
            report_mismatch("frame_height readback", 32'(m_height), rd);
        apb_access(1'b0, REG_DELAY_GAIN, '0, rd);
        if (rd !== APB_DW'(m_gain))
            report_mismatch("delay_gain readback", 32'(m_gain), rd);
    endtask

    task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [GAIN_W-1:0] g);
        reg_write(REG_FRAME_WIDTH, APB_DW'(w));
        reg_write(REG_FRAME_HEIGHT, APB_DW'(h));
        reg_write(REG_DELAY_GAIN, APB_DW'(g));
        settings_used++;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [MASK_W-1:0] mask);
        i_valid      <= 1'b1;
        i_pixel_in   <= pix;
        i_delay_mask <= mask;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_slit_scan(pix, mask);
        pixels_sent++;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // drop valid, let every pending beat come out, then let the pipe settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [MASK_W-1:0] pick_mask();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return MASK_W'($urandom);
    endfunction

    task automatic test_reset_defaults();
        check_registers();
        // gain 0 reads the previous slot, still cleared
        send_pixel(8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00);
        send_pixel(8'hAA, 8'h55);
    endtask

    task automatic test_register_access();
        wait_idle();
        set_geometry(9'd5, 9'd3, 8'd200);
        reg_write(REG_UNUSED, 32'hFFFF_FFFF);
        check_registers();
    endtask

    task automatic test_special_cases();
        int k;
        // shrink geometry while the raster sits past the new row end
        wait_idle();
        set_geometry(9'd2, 9'd2, 8'd255);
        for (k = 0; k < 4; k++)
            send_pixel(PIX_W'(8'h11 * (k + 1)), 8'hFF);
        for (k = 0; k < 4; k++)
            send_pixel(PIX_W'(8'hF0 - k), 8'h00);
        // zero width and height act as one: every beat ends a frame
        wait_idle();
        set_geometry(9'd0, 9'd0, 8'd255);
        send_pixel(8'h01, 8'h00);
        send_pixel(8'hFE, 8'h00);
        send_pixel(8'h7F, 8'hFF);
        send_pixel(8'h80, 8'h01);
        // delay index just below and at the clamp
        wait_idle();
        set_geometry(9'd1, 9'd1, 8'd110);
        send_pixel(8'h3C, 8'hFF);
        send_pixel(8'hC3, 8'hFF);
        wait_idle();
        set_geometry(9'd1, 9'd1, 8'd111);
        send_pixel(8'h5A, 8'hFF);
        send_pixel(8'hA5, 8'hFF);
        // oversized width and height saturate
        wait_idle();
        set_geometry(9'd511, 9'd300, 8'd77);
        check_registers();
        send_pixel(8'h00, 8'hFF);
        send_pixel(8'hFF, 8'h80);
        send_pixel(8'h42, 8'h7F);
    endtask

    task automatic test_backpressure();
        wait_idle();
        set_geometry(9'd3, 9'd2, 8'($urandom));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_req = 120;
        repeat (40) send_pixel(PIX_W'($urandom), pick_mask());
        wait_idle();
    endtask

    task automatic test_drain_pause();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (30) send_pixel(PIX_W'($urandom), pick_mask());
        // sender stops mid-frame until the output has caught up
        wait_idle();
        repeat (30) send_pixel(PIX_W'($urandom), pick_mask());
        wait_idle();
    endtask

    task automatic test_random_traffic(input int stop_at, input bit allow_idle);
        logic [DIM_W-1:0]  wv;
        logic [DIM_W-1:0]  hv;
        logic [GAIN_W-1:0] gv;
        int unsigned frame_px;
        int unsigned n;
        int pick;
        while (pixels_sent < stop_at) begin
            wait_idle();
            pick = $urandom_range(0, 11);
            case (pick)
                0: begin
                    wv = DIM_W'($urandom_range(0, 1));
                    hv = DIM_W'($urandom_range(0, 4));
                end
                1: begin
                    wv = DIM_W'($urandom_range(255, 256));
                    hv = 9'd1;
                end
                2: begin
                    wv = 9'd1;
                    hv = DIM_W'($urandom_range(255, 256));
                end
                3: begin
                    wv = DIM_W'($urandom_range(257, 511));
                    hv = DIM_W'($urandom_range(0, 2));
                end
                4: begin
                    wv = DIM_W'($urandom_range(0, 1));
                    hv = DIM_W'($urandom_range(257, 511));
                end
                default: begin
                    wv = DIM_W'($urandom_range(1, 6));
                    hv = DIM_W'($urandom_range(1, 5));
                end
            endcase
            case ($urandom_range(0, 5))
                0: gv = '0;
                1: gv = '1;
                2: gv = GAIN_W'($urandom_range(105, 115));
                default: gv = GAIN_W'($urandom);
            endcase
            set_geometry(wv, hv, gv);
            if ($urandom_range(0, 5) == 0)
                reg_write(REG_UNUSED, $urandom);
            check_registers();
            tx_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            rx_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            frame_px = eff_dim(wv, MAX_W) * eff_dim(hv, MAX_H);
            n = frame_px * $urandom_range(1, 18);
            if (n > 300)
                n = (frame_px > 300) ? frame_px : frame_px * (300 / frame_px);
            // now and then a broken frame, left for the next geometry
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(1, 3);
            repeat (n) send_pixel(PIX_W'($urandom), pick_mask());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_register_access();
        test_special_cases();
        test_backpressure();
        test_drain_pause();
        test_random_traffic(ITEM_TARGET - CALM_TAIL, 1'b1);
        test_random_traffic(ITEM_TARGET, 1'b0);
        wait_idle();
        $display("Covered %0d pixels and %0d frames over %0d register settings,",
                 pixels_sent, frames_seen, settings_used);
        $display("including zero and oversized geometry, clamped delays and output stalls.");
        if (mismatches == 0) begin
            $display("per_pixel_delay_slit_scan test passed");
        end else begin
            $display("per_pixel_delay_slit_scan test failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/ppd_pkg.sv
design/ppd_ram.sv
design/ppd_delay.sv
design/ppd_raster.sv
design/per_pixel_delay_slit_scan.sv
tb/sv/tb_per_pixel_delay_slit_scan.sv
